/* src/dsr_pkg.sv */
// dsr_pkg: shared constants, codes and controller/datapath types
// for the stepwise shortest-path block; no dependencies
package dsr_pkg;

	localparam int NODES           = 64;
	localparam int NODE_W          = 6;
	localparam int CNT_W           = 7;
	localparam int DIST_W          = 22;
	localparam int WEIGHT_W        = 16;
	localparam int STATUS_W        = 2;
	localparam int REQ_W           = 3;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_W           = 7;
	localparam int DEF_MAX_DEGREE  = 8;

	localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BEGIN = 3'd1;
	localparam logic [REQ_W-1:0] REQ_STEP  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FIN   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

	typedef enum logic [1:0] {
		DSEL_IDX,
		DSEL_DST,
		DSEL_SCAN
	} dist_sel_t;

	typedef enum logic [2:0] {
		RES_OK,
		RES_FIN,
		RES_FULL,
		RES_RANGE,
		RES_BEGIN,
		RES_RELAX,
		RES_READ
	} res_kind_t;

	typedef struct packed {
		logic      cap_in;
		logic      add_edge;
		logic      srch_begin;
		logic      clear_deg;
		logic      take_edge;
		logic      relax;
		logic      scan_start;
		logic      scan_en;
		logic      settle;
		logic      finish;
		dist_sel_t dist_sel;
		logic      res_load;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_code;
		logic             add_bad;
		logic             deg_full;
		logic             start_bad;
		logic             done;
		logic             edge_avail;
		logic             dst_bad;
		logic             improve;
		logic             idx_bad;
		logic             scan_last;
		logic             found;
		logic             out_busy;
	} stat_t;

endpackage

/* src/dsr_req_if.sv */
// dsr_req_if: request channel, valid/ready with the request fields
// depends on dsr_pkg
interface dsr_req_if;
	logic                          valid;
	logic                          ready;
	logic [dsr_pkg::REQ_W-1:0]     req_type;
	logic [dsr_pkg::NODE_W-1:0]    edge_src;
	logic [dsr_pkg::NODE_W-1:0]    edge_dst;
	logic [dsr_pkg::WEIGHT_W-1:0]  edge_weight;
	logic [dsr_pkg::NODE_W-1:0]    node_index;

	modport source (output valid, req_type, edge_src, edge_dst, edge_weight, node_index,
		input ready);
	modport sink (input valid, req_type, edge_src, edge_dst, edge_weight, node_index,
		output ready);
endinterface

/* src/dsr_res_if.sv */
// dsr_res_if: result channel, valid/ready with the result fields
// depends on dsr_pkg
interface dsr_res_if;
	logic                          valid;
	logic                          ready;
	logic [dsr_pkg::STATUS_W-1:0]  status;
	logic [dsr_pkg::NODE_W-1:0]    from_node;
	logic [dsr_pkg::NODE_W-1:0]    to_node;
	logic [dsr_pkg::DIST_W-1:0]    path_distance;
	logic                          reached;

	modport source (output valid, status, from_node, to_node, path_distance, reached,
		input ready);
	modport sink (input valid, status, from_node, to_node, path_distance, reached,
		output ready);
endinterface

/* src/dsr_datapath.sv */
// dsr_datapath: graph memories, search state, scan and relax logic, result register
// depends on dsr_pkg; driven by dsr_ctrl through cmd_t / stat_t
module dsr_datapath #(
	parameter int MAX_DEGREE = dsr_pkg::DEF_MAX_DEGREE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dsr_pkg::cmd_t                    cmd,
	output dsr_pkg::stat_t                   stat,
	input  logic                             wr_en,
	input  logic [dsr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [dsr_pkg::CFG_W-1:0]        wr_data,
	input  logic [dsr_pkg::REQ_W-1:0]        in_req_type,
	input  logic [dsr_pkg::NODE_W-1:0]       in_edge_src,
	input  logic [dsr_pkg::NODE_W-1:0]       in_edge_dst,
	input  logic [dsr_pkg::WEIGHT_W-1:0]     in_edge_weight,
	input  logic [dsr_pkg::NODE_W-1:0]       in_node_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [dsr_pkg::STATUS_W-1:0]     out_status,
	output logic [dsr_pkg::NODE_W-1:0]       out_from_node,
	output logic [dsr_pkg::NODE_W-1:0]       out_to_node,
	output logic [dsr_pkg::DIST_W-1:0]       out_path_distance,
	output logic                             out_reached
);
	localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
	localparam int EDGE_DEPTH = dsr_pkg::NODES * MAX_DEGREE;
	localparam int EADDR_W    = $clog2(EDGE_DEPTH);
	localparam int EDGE_W     = dsr_pkg::NODE_W + dsr_pkg::WEIGHT_W;
	localparam int NW         = dsr_pkg::NODE_W;
	localparam int CW         = dsr_pkg::CNT_W;
	localparam int DW         = dsr_pkg::DIST_W;
	localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

	// captured request
	logic [dsr_pkg::REQ_W-1:0]    req_q;
	logic [NW-1:0]                src_q, edst_q, idx_q;
	logic [dsr_pkg::WEIGHT_W-1:0] weight_q;

	// configuration
	logic [NW-1:0] start_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_eff;

	// memories
	logic [DEG_W-1:0]  deg_mem  [dsr_pkg::NODES];
	logic [EDGE_W-1:0] edge_mem [EDGE_DEPTH];
	logic [DW-1:0]     dist_mem [dsr_pkg::NODES];

	logic [dsr_pkg::NODES-1:0] deg_vld_q, reached_q, visited_q;
	logic [DEG_W-1:0]  deg_rd_q, deg_eff;
	logic              deg_rdv_q;
	logic [NW-1:0]     deg_addr;
	logic [EDGE_W-1:0] edge_rd_q;
	logic [EADDR_W-1:0] edge_raddr, edge_waddr;
	logic [DW-1:0]     dist_rd_q;
	logic [NW-1:0]     dist_addr, dist_waddr;
	logic [DW-1:0]     dist_wdata;
	logic              dist_we;

	// search state
	logic [NW-1:0]    cur_q, rdst_q, best_q, cand_idx_s1;
	logic [DEG_W-1:0] cursor_q;
	logic             active_q, done_q, found_q, cand_vld_s1;
	logic [DW-1:0]    base_q, nd_q, best_dist_q;
	logic [CW-1:0]    scan_idx_q;
	logic [NW-1:0]    scan_node;

	logic [DW:0]      sum;
	logic [DW-1:0]    nd;
	logic [NW-1:0]    e_dst;

	logic                          out_vld_q;
	logic [dsr_pkg::STATUS_W-1:0]  status_q;
	logic [NW-1:0]                 from_q, to_q;
	logic [DW-1:0]                 pdist_q;
	logic                          reach_q;

	logic [dsr_pkg::STATUS_W-1:0]  res_status;
	logic [NW-1:0]                 res_from, res_to;
	logic [DW-1:0]                 res_pdist;
	logic                          res_reach;

	always_comb begin
		if (count_q == '0) begin
			n_eff = CW'(1);
		end else if (count_q > CW'(dsr_pkg::NODES)) begin
			n_eff = CW'(dsr_pkg::NODES);
		end else begin
			n_eff = count_q;
		end
	end

	assign deg_eff    = deg_rdv_q ? deg_rd_q : '0;
	assign deg_addr   = (req_q == dsr_pkg::REQ_ADD) ? src_q : cur_q;
	assign edge_raddr = EADDR_W'(cur_q) * EADDR_W'(MAX_DEGREE) + EADDR_W'(cursor_q);
	assign edge_waddr = EADDR_W'(src_q) * EADDR_W'(MAX_DEGREE) + EADDR_W'(deg_eff);
	assign scan_node  = scan_idx_q[NW-1:0];

	always_comb begin
		case (cmd.dist_sel)
			dsr_pkg::DSEL_IDX:  dist_addr = idx_q;
			dsr_pkg::DSEL_DST:  dist_addr = rdst_q;
			dsr_pkg::DSEL_SCAN: dist_addr = scan_node;
			default:            dist_addr = idx_q;
		endcase
	end

	assign dist_we    = cmd.srch_begin | cmd.relax;
	assign dist_waddr = cmd.srch_begin ? start_q : rdst_q;
	assign dist_wdata = cmd.srch_begin ? '0 : nd_q;

	// saturating relaxation sum
	assign e_dst = edge_rd_q[NW-1:0];
	assign sum   = {1'b0, base_q} + (DW+1)'(edge_rd_q[NW +: dsr_pkg::WEIGHT_W]);
	assign nd    = sum[DW] ? DIST_MAX : sum[DW-1:0];

	// result fields
	always_comb begin
		res_status = dsr_pkg::ST_OK;
		res_from   = '0;
		res_to     = '0;
		res_pdist  = '0;
		res_reach  = 1'b0;
		case (cmd.res_kind)
			dsr_pkg::RES_FIN:   res_status = dsr_pkg::ST_FIN;
			dsr_pkg::RES_FULL:  res_status = dsr_pkg::ST_FULL;
			dsr_pkg::RES_RANGE: res_status = dsr_pkg::ST_RANGE;
			dsr_pkg::RES_BEGIN: begin
				res_from  = start_q;
				res_to    = start_q;
				res_reach = 1'b1;
			end
			dsr_pkg::RES_RELAX: begin
				res_from  = cur_q;
				res_to    = rdst_q;
				res_pdist = nd_q;
				res_reach = 1'b1;
			end
			dsr_pkg::RES_READ: begin
				res_pdist = reached_q[idx_q] ? dist_rd_q : '0;
				res_reach = reached_q[idx_q];
			end
			default: res_status = dsr_pkg::ST_OK;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		deg_rd_q  <= deg_mem[deg_addr];
		edge_rd_q <= edge_mem[edge_raddr];
		dist_rd_q <= dist_mem[dist_addr];
		if (cmd.add_edge) begin
			deg_mem[src_q]       <= deg_eff + DEG_W'(1);
			edge_mem[edge_waddr] <= {weight_q, edst_q};
		end
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			req_q    <= in_req_type;
			src_q    <= in_edge_src;
			edst_q   <= in_edge_dst;
			weight_q <= in_edge_weight;
			idx_q    <= in_node_index;
		end
		if (cmd.take_edge) begin
			nd_q   <= nd;
			rdst_q <= e_dst;
		end
		if (cmd.settle) begin
			base_q <= best_dist_q;
		end
		cand_idx_s1 <= scan_node;
		if (cand_vld_s1 && (!found_q || dist_rd_q < best_dist_q)) begin
			best_q      <= cand_idx_s1;
			best_dist_q <= dist_rd_q;
		end
		if (cmd.res_load) begin
			status_q <= res_status;
			from_q   <= res_from;
			to_q     <= res_to;
			pdist_q  <= res_pdist;
			reach_q  <= res_reach;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			count_q     <= CW'(dsr_pkg::NODES);
			deg_vld_q   <= '0;
			deg_rdv_q   <= 1'b0;
			reached_q   <= '0;
			visited_q   <= '0;
			cur_q       <= '0;
			cursor_q    <= '0;
			active_q    <= 1'b0;
			done_q      <= 1'b1;
			found_q     <= 1'b0;
			scan_idx_q  <= '0;
			cand_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					dsr_pkg::CFG_START: start_q <= wr_data[NW-1:0];
					dsr_pkg::CFG_COUNT: count_q <= wr_data[CW-1:0];
					default: ;
				endcase
			end
			deg_rdv_q <= deg_vld_q[deg_addr];
			if (cmd.clear_deg) begin
				deg_vld_q <= '0;
			end else if (cmd.add_edge) begin
				deg_vld_q[src_q] <= 1'b1;
			end
			if (cmd.srch_begin) begin
				reached_q <= {{(dsr_pkg::NODES-1){1'b0}}, 1'b1} << start_q;
				visited_q <= '0;
				cur_q     <= start_q;
				cursor_q  <= '0;
				active_q  <= 1'b0;
				done_q    <= 1'b0;
			end
			if (cmd.take_edge) begin
				cursor_q <= cursor_q + DEG_W'(1);
			end
			if (cmd.relax) begin
				reached_q[rdst_q] <= 1'b1;
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				active_q   <= 1'b0;
			end else if (cmd.scan_en && !stat.scan_last) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			cand_vld_s1 <= cmd.scan_en && !stat.scan_last && reached_q[scan_node]
				&& !visited_q[scan_node];
			if (cand_vld_s1 && (!found_q || dist_rd_q < best_dist_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.settle) begin
				visited_q[best_q] <= 1'b1;
				cur_q             <= best_q;
				cursor_q          <= '0;
				active_q          <= 1'b1;
			end
			if (cmd.finish) begin
				done_q   <= 1'b1;
				active_q <= 1'b0;
			end
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.req_code   = req_q;
		stat.add_bad    = ({1'b0, src_q} >= n_eff) || ({1'b0, edst_q} >= n_eff);
		stat.deg_full   = deg_eff >= DEG_W'(MAX_DEGREE);
		stat.start_bad  = {1'b0, start_q} >= n_eff;
		stat.done       = done_q;
		stat.edge_avail = active_q && (cursor_q < deg_eff);
		stat.dst_bad    = {1'b0, rdst_q} >= n_eff;
		stat.improve    = !(reached_q[rdst_q] && (dist_rd_q <= nd_q));
		stat.idx_bad    = {1'b0, idx_q} >= n_eff;
		stat.scan_last  = scan_idx_q >= n_eff;
		stat.found      = found_q;
		stat.out_busy   = out_vld_q && !out_ready;
	end

	assign out_valid         = out_vld_q;
	assign out_status        = status_q;
	assign out_from_node     = from_q;
	assign out_to_node       = to_q;
	assign out_path_distance = pdist_q;
	assign out_reached       = reach_q;

`ifndef NO_ASSERTIONS
	a_active_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !done_q)
		else $error("node active after search finished");
	a_visited_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(visited_q & ~reached_q) == '0)
		else $error("visited node without distance");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= DEG_W'(MAX_DEGREE))
		else $error("edge cursor beyond slot count");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !stat.out_busy)
		else $error("result register overwritten");
`endif
endmodule

/* src/dsr_ctrl.sv */
// dsr_ctrl: request sequencer for the shortest-path block
// depends on dsr_pkg; drives dsr_datapath through cmd_t / stat_t
module dsr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dsr_pkg::stat_t stat,
	output dsr_pkg::cmd_t  cmd
);
	typedef enum logic [9:0] {
		S_IDLE      = 10'b0000000001,
		S_DECODE    = 10'b0000000010,
		S_ADD_WR    = 10'b0000000100,
		S_READ_W    = 10'b0000001000,
		S_STEP_DEG  = 10'b0000010000,
		S_STEP_LOOP = 10'b0000100000,
		S_EDGE_B    = 10'b0001000000,
		S_EDGE_C    = 10'b0010000000,
		S_SCAN      = 10'b0100000000,
		S_SCAN_END  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.dist_sel = dsr_pkg::DSEL_IDX;
		cmd.res_kind = dsr_pkg::RES_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.out_busy) begin
					state_d = S_IDLE;
					case (stat.req_code)
						dsr_pkg::REQ_ADD: begin
							if (stat.add_bad) begin
								cmd.res_load = 1'b1;
								cmd.res_kind = dsr_pkg::RES_RANGE;
							end else begin
								state_d = S_ADD_WR;
							end
						end
						dsr_pkg::REQ_BEGIN: begin
							cmd.res_load = 1'b1;
							if (stat.start_bad) begin
								cmd.res_kind = dsr_pkg::RES_RANGE;
							end else begin
								cmd.srch_begin = 1'b1;
								cmd.res_kind   = dsr_pkg::RES_BEGIN;
							end
						end
						dsr_pkg::REQ_STEP: begin
							if (stat.done) begin
								cmd.res_load = 1'b1;
								cmd.res_kind = dsr_pkg::RES_FIN;
							end else begin
								state_d = S_STEP_DEG;
							end
						end
						dsr_pkg::REQ_READ: begin
							if (stat.idx_bad) begin
								cmd.res_load = 1'b1;
								cmd.res_kind = dsr_pkg::RES_RANGE;
							end else begin
								state_d = S_READ_W;
							end
						end
						dsr_pkg::REQ_CLEAR: begin
							cmd.clear_deg = 1'b1;
							cmd.res_load  = 1'b1;
							cmd.res_kind  = dsr_pkg::RES_OK;
						end
						default: begin
							cmd.res_load = 1'b1;
							cmd.res_kind = dsr_pkg::RES_RANGE;
						end
					endcase
				end
			end
			S_ADD_WR: begin
				cmd.res_load = 1'b1;
				if (stat.deg_full) begin
					cmd.res_kind = dsr_pkg::RES_FULL;
				end else begin
					cmd.add_edge = 1'b1;
					cmd.res_kind = dsr_pkg::RES_OK;
				end
				state_d = S_IDLE;
			end
			S_READ_W: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = dsr_pkg::RES_READ;
				state_d      = S_IDLE;
			end
			S_STEP_DEG: begin
				state_d = S_STEP_LOOP;
			end
			S_STEP_LOOP: begin
				if (stat.edge_avail) begin
					cmd.take_edge = 1'b1;
					state_d       = S_EDGE_B;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_EDGE_B: begin
				cmd.dist_sel = dsr_pkg::DSEL_DST;
				state_d      = stat.dst_bad ? S_STEP_DEG : S_EDGE_C;
			end
			S_EDGE_C: begin
				cmd.dist_sel = dsr_pkg::DSEL_DST;
				if (stat.improve) begin
					cmd.relax    = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_kind = dsr_pkg::RES_RELAX;
					state_d      = S_IDLE;
				end else begin
					state_d = S_STEP_DEG;
				end
			end
			S_SCAN: begin
				cmd.scan_en  = 1'b1;
				cmd.dist_sel = dsr_pkg::DSEL_SCAN;
				if (stat.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				if (stat.found) begin
					cmd.settle = 1'b1;
					state_d    = S_STEP_DEG;
				end else begin
					cmd.finish   = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_kind = dsr_pkg::RES_FIN;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* src/dijkstra_stepwise_relaxation.sv */
// Stepwise single-source shortest paths over a loaded graph of up to 64 nodes with
// MAX_DEGREE edge slots per node. One request is handled at a time; the next request is
// taken once the previous result is in the output register, and is decoded only when
// that register is free or being read. A step after the search has finished returns a
// finished status; otherwise it examines the edges of the settled node in turn, skipping
// a destination beyond node_count, and returns a result on the first edge that improves a
// distance. Each time a new node has to be settled, a linear scan over node_count nodes
// reads the distance memory; if no node is left, the step returns a finished status. In
// the worst case one step settles every remaining node whose edges all fail to improve.
// No clearing pass is needed after reset.
// depends on dsr_pkg, dsr_req_if, dsr_res_if, dsr_ctrl, dsr_datapath
module dijkstra_stepwise_relaxation #(
	parameter int MAX_DEGREE = dsr_pkg::DEF_MAX_DEGREE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dsr_req_if.sink                       req,
	dsr_res_if.source                     res,
	input  logic                          wr_en,
	input  logic [dsr_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [dsr_pkg::CFG_W-1:0]     wr_data
);
	dsr_pkg::cmd_t  cmd;
	dsr_pkg::stat_t stat;

	dsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsr_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.wr_en             (wr_en),
		.wr_index          (wr_index),
		.wr_data           (wr_data),
		.in_req_type       (req.req_type),
		.in_edge_src       (req.edge_src),
		.in_edge_dst       (req.edge_dst),
		.in_edge_weight    (req.edge_weight),
		.in_node_index     (req.node_index),
		.out_valid         (res.valid),
		.out_ready         (res.ready),
		.out_status        (res.status),
		.out_from_node     (res.from_node),
		.out_to_node       (res.to_node),
		.out_path_distance (res.path_distance),
		.out_reached       (res.reached)
	);
endmodule
